FILE: rtl/core/swp_pkg.sv
package swp_pkg;

	// Field widths
	localparam int unsigned RX_BYTE_W = 8;
	localparam int unsigned WEIGHT_W  = 19;
	localparam int unsigned ACC_W     = 20;
	localparam int unsigned FRAC_W    = 3;
	localparam int unsigned DIGIT_W   = 4;
	// Accumulator times ten plus a scaled digit fits here
	localparam int unsigned SUM_W     = ACC_W + 4;
	localparam int unsigned ADD_W     = 14;

	// Scale dialects
	typedef enum logic [1:0] {
		DIALECT_PLAIN_CR = 2'd0,
		DIALECT_INT_RS   = 2'd1,
		DIALECT_ACK_POLL = 2'd2,
		DIALECT_K_OR_CR  = 2'd3
	} dialect_t;

	// Request kinds
	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	// Weight window and limits
	localparam logic [ACC_W-1:0]  ACC_MAX     = '1;
	localparam logic [ACC_W-1:0]  WEIGHT_LOW  = ACC_W'(5000);
	localparam logic [ACC_W-1:0]  WEIGHT_HIGH = ACC_W'(300000);
	localparam logic [ADD_W-1:0]  DIGIT_UNIT  = ADD_W'(1000);
	localparam logic [ADD_W-1:0]  UNIT_TENTHS = ADD_W'(100);
	localparam logic [ADD_W-1:0]  UNIT_HUNDR  = ADD_W'(10);

	// Fraction digit counter codes
	localparam logic [FRAC_W-1:0] FRAC_NONE  = 3'd0;
	localparam logic [FRAC_W-1:0] FRAC_FIRST = 3'd1;
	localparam logic [FRAC_W-1:0] FRAC_SECOND = 3'd2;
	localparam logic [FRAC_W-1:0] FRAC_THIRD = 3'd3;
	localparam logic [FRAC_W-1:0] FRAC_DONE  = 3'd4;

	// Characters
	localparam logic [RX_BYTE_W-1:0] CH_ACK   = 8'h06;
	localparam logic [RX_BYTE_W-1:0] CH_DC1   = 8'h11;
	localparam logic [RX_BYTE_W-1:0] CH_RS    = 8'h1e;
	localparam logic [RX_BYTE_W-1:0] CH_EOT   = 8'h04;
	localparam logic [RX_BYTE_W-1:0] CH_ETX   = 8'h03;
	localparam logic [RX_BYTE_W-1:0] CH_ENQ   = 8'h05;
	localparam logic [RX_BYTE_W-1:0] CH_CR    = 8'h0d;
	localparam logic [RX_BYTE_W-1:0] CH_K     = 8'h6b;
	localparam logic [RX_BYTE_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [RX_BYTE_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [RX_BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [RX_BYTE_W-1:0] CH_NINE  = 8'h39;

endpackage

FILE: rtl/core/swp_if.sv
// Byte and tick requests from the receive side
interface swp_in_if import swp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [RX_BYTE_W-1:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// Parse results: weight report and reply byte
interface swp_out_if import swp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 weight_valid;
	logic [WEIGHT_W-1:0]  weight_value;
	logic                 reply_valid;
	logic [RX_BYTE_W-1:0] reply_byte;

	modport source (output valid, output weight_valid, output weight_value,
		output reply_valid, output reply_byte, input ready);
	modport sink   (input valid, input weight_valid, input weight_value,
		input reply_valid, input reply_byte, output ready);
endinterface

FILE: rtl/core/scale_weight_parser_top.sv
// Channel   | Dir | Carries
// ----------+-----+--------------------------------------------------
// in_ch     | in  | kind, rx_byte: received byte or tick
// out_ch    | out | weight_valid, weight_value, reply_valid, reply_byte
// cfg_we/.. | in  | dialect register write, no read-back
//
// One request per clock sustained while out_ch.ready holds; each request gives
// exactly one result, through the input register and then the result register.
// The accumulator update is one add and saturate between those registers.
// arst_n clears valids, the accumulator, the decimal counter and the dialect.
// A stalled result holds in its register while one more request is taken.
module scale_weight_parser_top import swp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	swp_in_if.sink      in_ch,
	swp_out_if.source   out_ch
);

	dialect_t             dialect_q;
	logic [ACC_W-1:0]     acc_q;
	logic [FRAC_W-1:0]    frac_q;

	logic                 valid_s1;
	kind_t                kind_s1;
	logic [RX_BYTE_W-1:0] byte_s1;

	logic                 valid_s2;
	logic                 wv_s2;
	logic [WEIGHT_W-1:0]  w_s2;
	logic                 rv_s2;
	logic [RX_BYTE_W-1:0] rb_s2;

	logic                 adv_s2;
	logic                 is_digit;
	logic                 is_point;
	logic                 is_term;
	logic [DIGIT_W-1:0]   digit;
	logic [SUM_W-1:0]     times10;
	logic [SUM_W-1:0]     base;
	logic [ADD_W-1:0]     addend;
	logic [SUM_W-1:0]     sum;
	logic [ACC_W-1:0]     sat_sum;
	logic [ACC_W-1:0]     acc_d;
	logic [FRAC_W-1:0]    frac_d;
	logic                 wv_d;
	logic [WEIGHT_W-1:0]  w_d;
	logic                 rv_d;
	logic [RX_BYTE_W-1:0] rb_d;

	// Handshake: input register moves on when the result register frees up
	assign adv_s2      = valid_s1 & (~valid_s2 | out_ch.ready);
	assign in_ch.ready = ~valid_s1 | adv_s2;

	// Dialect register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dialect_q <= DIALECT_PLAIN_CR;
		end else if (cfg_we) begin
			dialect_q <= dialect_t'(cfg_wdata);
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			kind_s1 <= kind_t'(in_ch.kind);
			byte_s1 <= in_ch.rx_byte;
		end
	end

	// Character classes
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_point = (byte_s1 == CH_DOT) || (byte_s1 == CH_COMMA);
	assign digit    = byte_s1[DIGIT_W-1:0];

	always_comb begin
		case (dialect_q)
			DIALECT_PLAIN_CR: is_term = (byte_s1 == CH_CR);
			DIALECT_INT_RS:   is_term = (byte_s1 == CH_RS);
			DIALECT_ACK_POLL: is_term = (byte_s1 == CH_K) || (byte_s1 == CH_EOT)
				|| (byte_s1 == CH_ETX);
			default:          is_term = (byte_s1 == CH_K) || (byte_s1 == CH_CR);
		endcase
	end

	// Digit accumulate: shift by ten or add a scaled fraction digit
	assign times10 = SUM_W'({acc_q, 3'b000}) + SUM_W'({acc_q, 1'b0});

	always_comb begin
		base   = SUM_W'(acc_q);
		addend = '0;
		if (dialect_q == DIALECT_INT_RS) begin
			base   = times10;
			addend = ADD_W'(digit);
		end else begin
			case (frac_q)
				FRAC_NONE: begin
					base   = times10;
					addend = ADD_W'(digit) * DIGIT_UNIT;
				end
				FRAC_FIRST:  addend = ADD_W'(digit) * UNIT_TENTHS;
				FRAC_SECOND: addend = ADD_W'(digit) * UNIT_HUNDR;
				FRAC_THIRD:  addend = ADD_W'(digit);
				default:     addend = '0;
			endcase
		end
	end

	assign sum     = base + SUM_W'(addend);
	assign sat_sum = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];

	// Next state and result
	always_comb begin
		acc_d  = acc_q;
		frac_d = frac_q;
		wv_d   = 1'b0;
		w_d    = '0;
		rv_d   = 1'b0;
		rb_d   = '0;
		if (kind_s1 == KIND_TICK) begin
			case (dialect_q)
				DIALECT_INT_RS, DIALECT_ACK_POLL: begin
					rv_d = 1'b1;
					rb_d = CH_ENQ;
				end
				DIALECT_K_OR_CR: begin
					rv_d = 1'b1;
					rb_d = CH_CR;
				end
				default: rv_d = 1'b0;
			endcase
		end else if (is_point) begin
			frac_d = FRAC_FIRST;
		end else if (dialect_q == DIALECT_ACK_POLL && byte_s1 == CH_ACK) begin
			rv_d = 1'b1;
			rb_d = CH_DC1;
		end else if (!is_digit) begin
			if (is_term) begin
				if (acc_q > WEIGHT_LOW && acc_q < WEIGHT_HIGH) begin
					wv_d = 1'b1;
					w_d  = acc_q[WEIGHT_W-1:0];
				end
				acc_d  = '0;
				frac_d = FRAC_NONE;
			end
		end else begin
			acc_d = sat_sum;
			if (dialect_q != DIALECT_INT_RS && frac_q != FRAC_NONE
				&& frac_q < FRAC_DONE) begin
				frac_d = frac_q + FRAC_W'(1);
			end
		end
	end

	// Parser state, updated as a request enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			frac_q <= FRAC_NONE;
		end else if (adv_s2) begin
			acc_q  <= acc_d;
			frac_q <= frac_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			wv_s2 <= wv_d;
			w_s2  <= w_d;
			rv_s2 <= rv_d;
			rb_s2 <= rb_d;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.weight_valid = wv_s2;
	assign out_ch.weight_value = w_s2;
	assign out_ch.reply_valid  = rv_s2;
	assign out_ch.reply_byte   = rb_s2;

endmodule

FILE: sim/tb_scale_weight_parser_top.sv
module tb_scale_weight_parser_top import swp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// Weight window and accumulator ceiling, in thousandths
	localparam int unsigned ACC_CEILING = 1048575;
	localparam int unsigned WINDOW_LOW  = 5000;
	localparam int unsigned WINDOW_HIGH = 300000;
	localparam int unsigned WHOLE_UNIT  = 1000;
	localparam int unsigned FRAC_SATURATED = 4;

	// Number of random phases and requests per phase
	localparam int PHASES     = 8;
	localparam int PHASE_REQS = 135;
	localparam int HOLD_OFF_CYCLES = 60;

	typedef struct packed {
		logic                 weight_valid;
		logic [WEIGHT_W-1:0]  weight_value;
		logic                 reply_valid;
		logic [RX_BYTE_W-1:0] reply_byte;
	} scale_report_t;

	// Tracks parser state and the reports still owed by the block
	class weight_tracker;
		dialect_t      dialect;
		int unsigned   weight_acc;
		int unsigned   frac_count;
		scale_report_t expected_reports[$];
		int unsigned   mismatches;

		function new();
			dialect    = DIALECT_PLAIN_CR;
			weight_acc = 0;
			frac_count = 0;
			mismatches = 0;
		endfunction

		function bit ends_weight(logic [RX_BYTE_W-1:0] c);
			case (dialect)
				DIALECT_PLAIN_CR: return c == CH_CR;
				DIALECT_INT_RS:   return c == CH_RS;
				DIALECT_ACK_POLL: return c == CH_K || c == CH_EOT || c == CH_ETX;
				default:          return c == CH_K || c == CH_CR;
			endcase
		endfunction

		function int unsigned clamp_acc(int unsigned v);
			return (v > ACC_CEILING) ? ACC_CEILING : v;
		endfunction

		// Advance the parser by one request and queue the report it gives
		function void note_request(kind_t kind, logic [RX_BYTE_W-1:0] c);
			scale_report_t rep;
			int unsigned   d;
			rep = '0;
			if (kind == KIND_TICK) begin
				if (dialect == DIALECT_INT_RS || dialect == DIALECT_ACK_POLL) begin
					rep.reply_valid = 1'b1;
					rep.reply_byte  = CH_ENQ;
				end else if (dialect == DIALECT_K_OR_CR) begin
					rep.reply_valid = 1'b1;
					rep.reply_byte  = CH_CR;
				end
			end else if (c == CH_DOT || c == CH_COMMA) begin
				frac_count = 1;
			end else if (dialect == DIALECT_ACK_POLL && c == CH_ACK) begin
				rep.reply_valid = 1'b1;
				rep.reply_byte  = CH_DC1;
			end else if (c < CH_ZERO || c > CH_NINE) begin
				if (ends_weight(c)) begin
					if (weight_acc > WINDOW_LOW && weight_acc < WINDOW_HIGH) begin
						rep.weight_valid = 1'b1;
						rep.weight_value = WEIGHT_W'(weight_acc);
					end
					weight_acc = 0;
					frac_count = 0;
				end
			end else begin
				d = int'(c - CH_ZERO);
				if (dialect == DIALECT_INT_RS)
					weight_acc = clamp_acc(weight_acc * 10 + d);
				else if (frac_count == 0)
					weight_acc = clamp_acc(weight_acc * 10 + WHOLE_UNIT * d);
				else begin
					case (frac_count)
						1: weight_acc = clamp_acc(weight_acc + 100 * d);
						2: weight_acc = clamp_acc(weight_acc + 10 * d);
						3: weight_acc = clamp_acc(weight_acc + d);
						default: ;
					endcase
					if (frac_count < FRAC_SATURATED)
						frac_count++;
				end
			end
			expected_reports.push_back(rep);
		endfunction

		// Compare one delivered report with the oldest one owed
		function void check_result(scale_report_t got);
			scale_report_t exp;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: report with nothing outstanding: wv=%0d w=%0d rv=%0d rb=%02h",
						$realtime, got.weight_valid, got.weight_value,
						got.reply_valid, got.reply_byte);
				return;
			end
			exp = expected_reports.pop_front();
			if (got.weight_valid !== exp.weight_valid || got.weight_value !== exp.weight_value ||
					got.reply_valid !== exp.reply_valid || got.reply_byte !== exp.reply_byte) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp wv=%0d w=%0d rv=%0d rb=%02h got wv=%0d w=%0d rv=%0d rb=%02h",
						$realtime, exp.weight_valid, exp.weight_value, exp.reply_valid,
						exp.reply_byte, got.weight_valid, got.weight_value,
						got.reply_valid, got.reply_byte);
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	swp_in_if  in_ch ();
	swp_out_if out_ch ();

	scale_weight_parser_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	weight_tracker tracker = new();

	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int requests_sent   = 0;
	logic hold_toggle   = 1'b0;

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Receiver: random stalls, plus a long hold-off when requested
	initial begin
		int   hold_left;
		logic hold_seen;
		hold_left    = 0;
		hold_seen    = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else
				out_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// Check every delivered report
	always @(posedge clk) begin
		scale_report_t got;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.weight_valid = out_ch.weight_valid;
			got.weight_value = out_ch.weight_value;
			got.reply_valid  = out_ch.reply_valid;
			got.reply_byte   = out_ch.reply_byte;
			tracker.check_result(got);
		end
	end

	// Offer one request and hold it until taken; entered and left at a falling edge
	task automatic put_request(input kind_t kind, input logic [RX_BYTE_W-1:0] c);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid   = 1'b1;
		in_ch.kind    = kind;
		in_ch.rx_byte = c;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		tracker.note_request(kind, c);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic put_byte(input logic [RX_BYTE_W-1:0] c);
		put_request(KIND_BYTE, c);
	endtask

	// rx_byte is don't-care on a tick, so drive noise on it
	task automatic put_tick();
		put_request(KIND_TICK, RX_BYTE_W'($urandom_range(255)));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_digit();
		put_byte(CH_ZERO + RX_BYTE_W'($urandom_range(9)));
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_dialect(input dialect_t d);
		cfg_we    = 1'b1;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.dialect = d;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin sender_idle_pct = 0;  stall_pct = 0;  end
			1: begin sender_idle_pct = 71; stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  stall_pct = 71; end
			default: begin sender_idle_pct = 28; stall_pct = 28; end
		endcase
	endtask

	function automatic logic [RX_BYTE_W-1:0] end_char(input dialect_t d);
		case (d)
			DIALECT_PLAIN_CR: return CH_CR;
			DIALECT_INT_RS:   return CH_RS;
			DIALECT_ACK_POLL: begin
				case ($urandom_range(2))
					0: return CH_K;
					1: return CH_EOT;
					default: return CH_ETX;
				endcase
			end
			default: return $urandom_range(1) ? CH_K : CH_CR;
		endcase
	endfunction

	// One reading: integer digits, optional fraction, terminator; sometimes broken
	task automatic send_reading();
		int unsigned roll;
		int unsigned int_len;
		int unsigned frac_len;
		dialect_t    term_dialect;
		roll = $urandom_range(99);
		if (tracker.dialect == DIALECT_INT_RS)
			int_len = (roll < 6) ? $urandom_range(7, 9) : $urandom_range(4, 6);
		else
			int_len = (roll < 6) ? $urandom_range(6, 8) : $urandom_range(1, 3);
		for (int i = 0; i < int_len; i++) begin
			if ($urandom_range(99) < 4)
				put_tick();
			put_digit();
		end
		if ($urandom_range(99) < 60) begin
			put_byte($urandom_range(1) ? CH_DOT : CH_COMMA);
			frac_len = $urandom_range(0, 5);
			for (int i = 0; i < frac_len; i++)
				put_digit();
			// repeated decimal point restarts the fraction
			if ($urandom_range(99) < 6) begin
				put_byte($urandom_range(1) ? CH_DOT : CH_COMMA);
				put_digit();
			end
		end
		if ($urandom_range(99) < 5)
			put_byte(CH_ACK);
		roll = $urandom_range(99);
		if (roll < 5)
			return;
		term_dialect = (roll < 15) ? dialect_t'($urandom_range(3)) : tracker.dialect;
		put_byte(end_char(term_dialect));
	endtask

	// Run time limit
	initial begin
		#400000;
		$display("FAIL scale_weight_parser_top");
		$finish;
	end

	// Stimulus
	initial begin
		dialect_t phase_dialects [PHASES];
		int       phase_start;
		int       roll;
		bit       hold_done;
		bit       pause_done;
		phase_dialects = '{DIALECT_PLAIN_CR, DIALECT_INT_RS, DIALECT_ACK_POLL, DIALECT_K_OR_CR,
			DIALECT_K_OR_CR, DIALECT_ACK_POLL, DIALECT_INT_RS, DIALECT_PLAIN_CR};
		hold_done     = 1'b0;
		pause_done    = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = DIALECT_PLAIN_CR;
		in_ch.valid   = 1'b0;
		in_ch.kind    = KIND_BYTE;
		in_ch.rx_byte = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: window edges, unpolled tick, three-digit fraction
		set_idling(0);
		write_dialect(DIALECT_PLAIN_CR);
		put_tick();
		send_text("5");
		put_byte(CH_CR);
		send_text("299.999");
		put_byte(CH_CR);
		wait_drained();
		// ACK answer, poll, saturated fraction, k terminator
		write_dialect(DIALECT_ACK_POLL);
		put_byte(CH_ACK);
		put_tick();
		send_text("12.3456");
		put_byte(CH_K);
		wait_drained();
		// integer dialect ignores the decimal point
		write_dialect(DIALECT_INT_RS);
		put_tick();
		send_text("5,1");
		put_byte(CH_RS);
		wait_drained();
		write_dialect(DIALECT_K_OR_CR);
		put_tick();
		put_byte(8'hff);

		// Random phases over dialects and idling modes
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			write_dialect(phase_dialects[phase]);
			set_idling((phase + phase / 4) % 4);
			phase_start = requests_sent;
			while (requests_sent < phase_start + PHASE_REQS) begin
				if (phase == 0 && !hold_done && requests_sent >= phase_start + 30) begin
					hold_toggle <= ~hold_toggle;
					hold_done = 1'b1;
				end
				if (phase == 0 && !pause_done && requests_sent >= phase_start + 90) begin
					wait_drained();
					pause_done = 1'b1;
				end
				roll = $urandom_range(99);
				if (roll < 78)
					send_reading();
				else if (roll < 86)
					put_tick();
				else if (roll < 90)
					put_byte(CH_ACK);
				else
					put_byte(RX_BYTE_W'($urandom_range(255)));
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("PASS scale_weight_parser_top");
		else
			$display("FAIL scale_weight_parser_top");
		$finish;
	end

endmodule
